// ----- rtl/lsfh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN slave frame handler package
// Shared constants, codes, types and table helpers of the frame handler.
// ----------------------------------------------------------------------------
package lsfh_pkg;

  localparam int TABLE_ENTRIES  = 4;
  localparam int MAX_DATA_BYTES = 8;

  localparam logic [7:0] SYNC_FIELD = 8'h55;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_IDS      = 2'd0,
    REG_ROLES    = 2'd1,
    REG_SIZES    = 2'd2,
    REG_ENHANCED = 2'd3
  } reg_idx_t;

  // Input actions; the fourth code carries no meaning.
  typedef enum logic [1:0] {
    ACT_BREAK  = 2'd0,
    ACT_RXBYTE = 2'd1,
    ACT_TXBYTE = 2'd2
  } act_t;

  // Message table roles.
  typedef enum logic [1:0] {
    ROLE_UNUSED = 2'd0,
    ROLE_LISTEN = 2'd1,
    ROLE_OWN    = 2'd2
  } role_t;

  // Result events.
  typedef enum logic [3:0] {
    EV_LISTEN  = 4'd0,
    EV_OWN     = 4'd1,
    EV_SYNCERR = 4'd2,
    EV_PARERR  = 4'd3,
    EV_UNKNOWN = 4'd4,
    EV_RXDATA  = 4'd5,
    EV_OK      = 4'd6,
    EV_CSERR   = 4'd7,
    EV_TXDATA  = 4'd8,
    EV_TXSUM   = 4'd9
  } ev_t;

  // Frame phase, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_SYNC   = 6'b000010,
    PH_PID    = 6'b000100,
    PH_RXDATA = 6'b001000,
    PH_RXSUM  = 6'b010000,
    PH_TXDATA = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic [1:0] entry_index;
    logic [7:0] byte_value;
    logic [3:0] byte_position;
    logic       last;
  } res_t;

  // Data length of table entry k, limited to eight and to MAX_DATA_BYTES.
  function automatic logic [3:0] entry_size(logic [15:0] sizes, logic [1:0] k);
    logic [3:0] s;
    s = sizes[4*k +: 4];
    if (s > 4'd8) s = 4'd8;
    if (s > 4'(MAX_DATA_BYTES)) s = 4'(MAX_DATA_BYTES);
    return s;
  endfunction

endpackage

// ----- rtl/lin_slave_frame_handler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN slave frame handler
// Follows LIN frames from the slave side: header check, ID lookup, and
// reception or transmission of the response with its checksum.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_action, in_data_byte
//   out_     output     out_valid / out_ready  event, entry, byte, position, last
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An accepted item lands in an input register and is handled once the queue
// has room, by one pass of logic that writes up to two results into a two-entry
// result queue. One item per cycle is sustained while each item yields at
// most one result and the results are taken; an item with two results needs
// two output transfers. The queue depth is what limits the rate under stalls.
// Reset (rst_n low, synchronous) clears the phase, counters, queue and all
// configuration registers. The configuration port is always ready.
module lin_slave_frame_handler
  import lsfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_res,
  output logic [1:0]  out_entry_index,
  output logic [7:0]  out_byte_value,
  output logic [3:0]  out_byte_position,
  output logic        out_last,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  // Configuration registers.
  logic [23:0] ids_r;
  logic [7:0]  roles_r;
  logic [15:0] sizes_r;
  logic        enhanced_r;

  // Input register.
  logic        s1_valid_r;
  logic [1:0]  s1_action_r;
  logic [7:0]  s1_byte_r;

  // Frame state.
  phase_t      phase_r, phase_nxt;
  logic [1:0]  entry_r, entry_nxt;
  logic [3:0]  bytes_done_r, bytes_done_nxt;
  logic [7:0]  sum_r, sum_nxt;

  // Result queue, slot 0 is the head.
  res_t        q_r [2];
  res_t        q_nxt [2];
  logic [1:0]  cnt_r, cnt_nxt;

  // Handling of the registered item.
  res_t        res0, res1;
  logic [1:0]  nres;
  logic        pop, fire;
  logic [1:0]  rem, free;

  // Header decode helpers.
  logic [5:0]  pid_id;
  logic        par_ok;
  logic        hit;
  logic [1:0]  hit_idx;
  logic [1:0]  hit_role;
  logic [3:0]  hit_size;
  logic [3:0]  cur_size;
  logic [3:0]  bd_inc;
  logic [7:0]  sum_add;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ids_r      <= '0;
      roles_r    <= '0;
      sizes_r    <= '0;
      enhanced_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_IDS:      ids_r      <= cfg_data;
        REG_ROLES:    roles_r    <= cfg_data[7:0];
        REG_SIZES:    sizes_r    <= cfg_data[15:0];
        REG_ENHANCED: enhanced_r <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // The queue pops the head on an output transfer; what is left decides how
  // many fresh results fit in this cycle.
  assign pop      = out_valid && out_ready;
  assign rem      = cnt_r - 2'(pop);
  assign free     = 2'd2 - rem;
  assign fire     = s1_valid_r && (nres <= free);
  assign in_ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_data_byte;
    end
  end

  // Protected identifier: parity bits P0 and P1 over the 6-bit ID.
  assign pid_id = s1_byte_r[5:0];
  assign par_ok = (s1_byte_r[6] == (s1_byte_r[0] ^ s1_byte_r[1] ^ s1_byte_r[2] ^ s1_byte_r[4]))
               && (s1_byte_r[7] == ~(s1_byte_r[1] ^ s1_byte_r[3] ^ s1_byte_r[4] ^ s1_byte_r[5]));

  // Parallel compare against all entries; the lowest matching entry wins.
  always_comb begin
    logic [1:0] role_k;
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
      role_k = roles_r[2*k +: 2];
      if ((role_k == ROLE_LISTEN || role_k == ROLE_OWN) && ids_r[6*k +: 6] == pid_id) begin
        hit     = 1'b1;
        hit_idx = 2'(k);
      end
    end
  end

  assign hit_role = roles_r[2*hit_idx +: 2];
  assign hit_size = entry_size(sizes_r, hit_idx);
  assign cur_size = entry_size(sizes_r, entry_r);
  assign bd_inc   = 4'(bytes_done_r + 4'd1);
  assign sum_add  = 8'(sum_r + s1_byte_r);

  always_comb begin
    logic [7:0] start_sum;
    start_sum      = enhanced_r ? {2'b00, pid_id} : 8'h00;
    phase_nxt      = phase_r;
    entry_nxt      = entry_r;
    bytes_done_nxt = bytes_done_r;
    sum_nxt        = sum_r;
    nres           = 2'd0;
    res0           = '{event_res: EV_SYNCERR, entry_index: 2'd0, byte_value: s1_byte_r,
                       byte_position: 4'd0, last: 1'b1};
    res1           = '{event_res: EV_TXSUM, entry_index: entry_r, byte_value: ~sum_add,
                       byte_position: bd_inc, last: 1'b1};

    priority if (s1_action_r == ACT_BREAK) begin
      // A break drops any frame in progress and waits for the sync byte.
      phase_nxt      = PH_SYNC;
      bytes_done_nxt = '0;
      sum_nxt        = '0;
    end else if (s1_action_r == ACT_RXBYTE) begin
      unique case (phase_r)
        PH_SYNC: begin
          if (s1_byte_r == SYNC_FIELD) begin
            phase_nxt = PH_PID;
          end else begin
            phase_nxt = PH_IDLE;
            nres      = 2'd1;
          end
        end
        PH_PID: begin
          phase_nxt = PH_IDLE;
          nres      = 2'd1;
          if (!par_ok) begin
            res0.event_res = EV_PARERR;
          end else if (!hit) begin
            res0.event_res  = EV_UNKNOWN;
            res0.byte_value = {2'b00, pid_id};
          end else begin
            entry_nxt        = hit_idx;
            bytes_done_nxt   = '0;
            sum_nxt          = start_sum;
            res0.entry_index = hit_idx;
            res0.byte_value  = {2'b00, pid_id};
            if (hit_role == ROLE_LISTEN) begin
              res0.event_res = EV_LISTEN;
              phase_nxt      = (hit_size != 4'd0) ? PH_RXDATA : PH_RXSUM;
            end else begin
              res0.event_res = EV_OWN;
              if (hit_size != 4'd0) begin
                phase_nxt = PH_TXDATA;
              end else begin
                // Owner with an empty response: the checksum follows at once.
                nres               = 2'd2;
                res0.last          = 1'b0;
                res1.entry_index   = hit_idx;
                res1.byte_value    = ~start_sum;
                res1.byte_position = 4'd0;
              end
            end
          end
        end
        PH_RXDATA: begin
          nres               = 2'd1;
          sum_nxt            = sum_add;
          bytes_done_nxt     = bd_inc;
          res0.event_res     = EV_RXDATA;
          res0.entry_index   = entry_r;
          res0.byte_position = bytes_done_r;
          if (bd_inc >= cur_size) phase_nxt = PH_RXSUM;
        end
        PH_RXSUM: begin
          nres               = 2'd1;
          phase_nxt          = PH_IDLE;
          res0.event_res     = (~sum_r == s1_byte_r) ? EV_OK : EV_CSERR;
          res0.entry_index   = entry_r;
          res0.byte_position = bytes_done_r;
        end
        default: ;
      endcase
    end else if (s1_action_r == ACT_TXBYTE && phase_r == PH_TXDATA) begin
      sum_nxt            = sum_add;
      bytes_done_nxt     = bd_inc;
      res0.event_res     = EV_TXDATA;
      res0.entry_index   = entry_r;
      res0.byte_position = bytes_done_r;
      if (bd_inc >= cur_size) begin
        phase_nxt = PH_IDLE;
        nres      = 2'd2;
        res0.last = 1'b0;
      end else begin
        nres = 2'd1;
      end
    end else begin
      nres = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      entry_r      <= '0;
      bytes_done_r <= '0;
      sum_r        <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      entry_r      <= entry_nxt;
      bytes_done_r <= bytes_done_nxt;
      sum_r        <= sum_nxt;
    end
  end

  // Queue update: surviving entries shift toward the head, new results fill
  // the slots behind them in order.
  always_comb begin
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = q_r[1];
    if (fire && rem == 2'd0) begin
      if (nres != 2'd0) q_nxt[0] = res0;
      if (nres == 2'd2) q_nxt[1] = res1;
    end else if (fire && rem == 2'd1) begin
      if (nres != 2'd0) q_nxt[1] = res0;
    end
    cnt_nxt = rem + (fire ? nres : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_valid         = (cnt_r != 2'd0);
  assign out_event_res     = q_r[0].event_res;
  assign out_entry_index   = q_r[0].entry_index;
  assign out_byte_value    = q_r[0].byte_value;
  assign out_byte_position = q_r[0].byte_position;
  assign out_last          = q_r[0].last;

`ifndef SYNTHESIS
  // A result that is not the last of its item always has its partner queued.
  a_pair_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd0 && !q_r[0].last) |-> cnt_r == 2'd2)
    else $error("first of a result pair queued without its partner");

  // The frame state moves only when the held item is handled.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(phase_r) && $stable(bytes_done_r) && $stable(sum_r)))
    else $error("frame state changed without a handled item");

  // The byte count never runs past the longest response.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_done_r <= 4'(MAX_DATA_BYTES))
    else $error("byte count beyond the longest response");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN slave frame handler testbench
// Drives break, bus and host bytes through the valid/ready input channel and
// checks every result transfer against a cycle-free model of the frame
// handler kept in this file. The message table is rewritten between phases
// through the configuration port, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top
  import lsfh_pkg::*;
();

  // The fourth action code and the fourth role code carry no meaning.
  localparam logic [1:0] ACT_NONE   = 2'd3;
  localparam logic [1:0] ROLE_SPARE = 2'd3;

  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ROUNDS = 10;
  localparam int ROUND_ITEMS   = 160;
  localparam int REPORT_LIMIT  = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = '0;
  logic [7:0]  in_data_byte = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_event_res;
  logic [1:0]  out_entry_index;
  logic [7:0]  out_byte_value;
  logic [3:0]  out_byte_position;
  logic        out_last;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lin_slave_frame_handler i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_res     (out_event_res),
    .out_entry_index   (out_entry_index),
    .out_byte_value    (out_byte_value),
    .out_byte_position (out_byte_position),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Frame model: a copy of the message table and of the frame state, advanced
  // once per accepted input transfer. Every result it produces is queued in
  // pending_events until the matching output transfer shows up.
  // --------------------------------------------------------------------------
  logic [23:0] tbl_ids      = '0;
  logic [7:0]  tbl_roles    = '0;
  logic [15:0] tbl_sizes    = '0;
  logic        tbl_enhanced = 1'b0;

  phase_t      fr_phase = PH_IDLE;
  logic [1:0]  fr_entry = '0;
  logic [3:0]  fr_count = '0;
  logic [7:0]  fr_sum   = '0;
  logic [5:0]  fr_id    = '0;

  res_t pending_events[$];

  int handled_items  = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int burst_left     = 1;

  // Protected identifier: the ID with parity bits P0 and P1 on top.
  function automatic logic [7:0] protect_id(logic [5:0] id);
    logic p0, p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // Response length of a table entry; the nibble saturates at eight bytes.
  function automatic logic [3:0] data_len(logic [1:0] k);
    logic [3:0] n;
    int         cap;
    cap = (MAX_DATA_BYTES < 8) ? MAX_DATA_BYTES : 8;
    n = tbl_sizes[4*k +: 4];
    return (n > 4'(cap)) ? 4'(cap) : n;
  endfunction

  function automatic void push_event(ev_t ev, logic [1:0] idx, logic [7:0] val,
                                     logic [3:0] pos, logic fin);
    res_t r;
    r.event_res     = ev;
    r.entry_index   = idx;
    r.byte_value    = val;
    r.byte_position = pos;
    r.last          = fin;
    pending_events.push_back(r);
  endfunction

  // Parity check and table lookup on the protected identifier.
  function automatic void resolve_pid(logic [7:0] pid);
    logic [5:0] id;
    logic [1:0] role;
    logic [3:0] len;
    int         k;
    int         hit;
    id = pid[5:0];
    hit = -1;
    fr_phase = PH_IDLE;
    if (protect_id(id) != pid) begin
      push_event(EV_PARERR, 2'd0, pid, 4'd0, 1'b1);
      return;
    end
    // The first entry with a live role and the same ID wins.
    for (k = 0; k < TABLE_ENTRIES && k < 4; k++) begin
      role = tbl_roles[2*k +: 2];
      if (hit < 0 && (role == ROLE_LISTEN || role == ROLE_OWN) && tbl_ids[6*k +: 6] == id)
        hit = k;
    end
    if (hit < 0) begin
      push_event(EV_UNKNOWN, 2'd0, {2'b00, id}, 4'd0, 1'b1);
      return;
    end
    fr_entry = 2'(hit);
    fr_id    = id;
    fr_count = '0;
    fr_sum   = tbl_enhanced ? {2'b00, id} : 8'h00;
    role     = tbl_roles[2*hit +: 2];
    len      = data_len(fr_entry);
    if (role == ROLE_LISTEN) begin
      fr_phase = (len != 0) ? PH_RXDATA : PH_RXSUM;
      push_event(EV_LISTEN, fr_entry, {2'b00, id}, 4'd0, 1'b1);
    end else if (len != 0) begin
      fr_phase = PH_TXDATA;
      push_event(EV_OWN, fr_entry, {2'b00, id}, 4'd0, 1'b1);
    end else begin
      // An owner with nothing to send closes the frame with its checksum.
      push_event(EV_OWN, fr_entry, {2'b00, id}, 4'd0, 1'b0);
      push_event(EV_TXSUM, fr_entry, ~fr_sum, 4'd0, 1'b1);
    end
  endfunction

  // Advances the frame by one input item. Returns 1 unless the item is ignored.
  function automatic bit lin_slave_step(logic [1:0] act, logic [7:0] b);
    logic [3:0] pos;
    case (act)
      ACT_BREAK: begin
        fr_phase = PH_SYNC;
        fr_count = '0;
        fr_sum   = '0;
        return 1'b1;
      end
      ACT_RXBYTE: begin
        case (fr_phase)
          PH_SYNC: begin
            if (b == SYNC_FIELD) begin
              fr_phase = PH_PID;
            end else begin
              fr_phase = PH_IDLE;
              push_event(EV_SYNCERR, 2'd0, b, 4'd0, 1'b1);
            end
            return 1'b1;
          end
          PH_PID: begin
            resolve_pid(b);
            return 1'b1;
          end
          PH_RXDATA: begin
            pos = fr_count;
            fr_sum = fr_sum + b;
            fr_count = fr_count + 4'd1;
            if (fr_count >= data_len(fr_entry))
              fr_phase = PH_RXSUM;
            push_event(EV_RXDATA, fr_entry, b, pos, 1'b1);
            return 1'b1;
          end
          PH_RXSUM: begin
            fr_phase = PH_IDLE;
            push_event((8'(~fr_sum) == b) ? EV_OK : EV_CSERR, fr_entry, b, fr_count, 1'b1);
            return 1'b1;
          end
          default: return 1'b0;
        endcase
      end
      ACT_TXBYTE: begin
        if (fr_phase == PH_TXDATA) begin
          pos = fr_count;
          fr_sum = fr_sum + b;
          fr_count = fr_count + 4'd1;
          // A length cut below the count in mid frame also ends the response.
          if (fr_count >= data_len(fr_entry)) begin
            fr_phase = PH_IDLE;
            push_event(EV_TXDATA, fr_entry, b, pos, 1'b0);
            push_event(EV_TXSUM, fr_entry, ~fr_sum, fr_count, 1'b1);
          end else begin
            push_event(EV_TXDATA, fr_entry, b, pos, 1'b1);
          end
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking. Each output transfer is compared field by field with the
  // oldest pending event.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    res_t seen;
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      seen.event_res     = out_event_res;
      seen.entry_index   = out_entry_index;
      seen.byte_value    = out_byte_value;
      seen.byte_position = out_byte_position;
      seen.last          = out_last;
      if (pending_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected result ev=%0d entry=%0d byte=%02h pos=%0d last=%0d",
                   $time, seen.event_res, seen.entry_index, seen.byte_value,
                   seen.byte_position, seen.last);
      end else begin
        want = pending_events.pop_front();
        if (seen.event_res !== want.event_res || seen.entry_index !== want.entry_index ||
            seen.byte_value !== want.byte_value ||
            seen.byte_position !== want.byte_position || seen.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"%0t: expected ev=%0d entry=%0d byte=%02h pos=%0d last=%0d, ",
                      "got ev=%0d entry=%0d byte=%02h pos=%0d last=%0d"},
                     $time, want.event_res, want.entry_index, want.byte_value,
                     want.byte_position, want.last, seen.event_res, seen.entry_index,
                     seen.byte_value, seen.byte_position, seen.last);
        end
      end
    end
  end

  // The result side stalls on a pattern redrawn whenever the low nine tick
  // bits wrap: always ready, coin flips, one stall in four, and long stalls.
  logic [15:0] stall_tick = '0;
  logic [1:0]  stall_mode = '0;

  always @(posedge clk) begin
    stall_tick <= stall_tick + 16'd1;
    if (stall_tick[8:0] == 9'd0)
      stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= 1'($urandom_range(0, 1));
      2'd2:    out_ready <= (stall_tick[1:0] != 2'd0);
      default: out_ready <= (stall_tick[3:0] < 4'd4);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_events.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // One input transfer. The sender works in bursts; after the last item of a
  // burst it drops valid for a random gap.
  task automatic send_item(logic [1:0] act, logic [7:0] b);
    in_valid     <= 1'b1;
    in_action    <= act;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (lin_slave_step(act, b))
      handled_items++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 8);
    end
  endtask

  // Waits until every pending result has arrived and the block has had time
  // to finish items that produce none.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One configuration transfer; valid is left high for a following one.
  task automatic cfg_transfer(reg_idx_t idx, logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IDS:   tbl_ids = value;
      REG_ROLES: tbl_roles = value[7:0];
      REG_SIZES: tbl_sizes = value[15:0];
      default:   tbl_enhanced = value[0];
    endcase
  endtask

  task automatic program_table(logic [23:0] ids, logic [23:0] roles,
                               logic [23:0] sizes, logic [23:0] enhanced);
    settle();
    cfg_transfer(REG_IDS, ids);
    cfg_transfer(REG_ROLES, roles);
    cfg_transfer(REG_SIZES, sizes);
    cfg_transfer(REG_ENHANCED, enhanced);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_header(logic [5:0] id);
    send_item(ACT_BREAK, 8'h00);
    send_item(ACT_RXBYTE, SYNC_FIELD);
    send_item(ACT_RXBYTE, protect_id(id));
  endtask

  // Table used by the directed tests: entry 1 repeats the ID of entry 0 and
  // must be shadowed by it, entry 3 carries the meaningless role.
  localparam logic [23:0] DIR_IDS   = {6'h3F, 6'h21, 6'h10, 6'h10};
  localparam logic [23:0] DIR_ROLES = {16'h0, ROLE_SPARE, ROLE_OWN, ROLE_OWN, ROLE_LISTEN};
  localparam logic [23:0] DIR_SIZES = {8'h0, 4'h0, 4'hF, 4'h4, 4'h2};

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Header failures and ignored items with the table as it comes out of reset.
  task automatic test_header_checks();
    send_item(ACT_RXBYTE, 8'hA5);        // bus byte while idle
    send_item(ACT_NONE, 8'hFF);
    send_item(ACT_TXBYTE, 8'h00);        // host byte with no response running
    send_item(ACT_BREAK, 8'hFF);
    send_item(ACT_RXBYTE, 8'h00);        // bad sync byte
    send_item(ACT_BREAK, 8'h00);
    send_item(ACT_RXBYTE, SYNC_FIELD);
    send_item(ACT_RXBYTE, 8'hFF);        // parity bits do not match
    send_header(6'h3F);                  // every entry unused
  endtask

  // Listener frame with a good checksum, duplicate ID resolved to entry 0.
  task automatic test_listener_response();
    program_table(DIR_IDS, DIR_ROLES, DIR_SIZES, 24'h0);
    send_header(6'h10);
    send_item(ACT_RXBYTE, 8'h00);
    send_item(ACT_RXBYTE, 8'hFF);
    send_item(ACT_RXBYTE, ~fr_sum);
  endtask

  // Owner frame with a stray bus byte, and its length cut below the count
  // while the response is under way.
  task automatic test_owner_response();
    send_header(6'h21);
    send_item(ACT_TXBYTE, 8'hFF);
    send_item(ACT_RXBYTE, 8'h12);
    send_item(ACT_TXBYTE, 8'h80);
    settle();
    cfg_transfer(REG_SIZES, {8'h0, 4'h0, 4'h1, 4'h4, 4'h2});
    cfg_valid <= 1'b0;
    send_item(ACT_TXBYTE, 8'h01);
  endtask

  // Zero-length listener and owner under the enhanced checksum, and an ID
  // that only the meaningless role would match.
  task automatic test_short_frames();
    program_table(DIR_IDS, DIR_ROLES, 24'h0, 24'h1);
    send_header(6'h10);
    send_item(ACT_RXBYTE, 8'h00);        // wrong checksum
    send_header(6'h21);
    send_header(6'h3F);
  endtask

  // One random frame: mostly well formed with random content, the rest noise,
  // broken headers and responses cut short by the next break.
  task automatic random_frame();
    int         pick;
    int         k;
    logic [5:0] id;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, 3);
    id = ($urandom_range(0, 6) == 0) ? 6'($urandom) : tbl_ids[6*k +: 6];
    if (pick < 8) begin
      send_item(2'($urandom), 8'($urandom));
      return;
    end
    send_item(ACT_BREAK, 8'($urandom));
    if (pick < 12) begin
      send_item(ACT_RXBYTE, 8'($urandom));
      return;
    end
    send_item(ACT_RXBYTE, SYNC_FIELD);
    if (pick < 17) begin
      send_item(ACT_RXBYTE, protect_id(id) ^ (8'h40 << $urandom_range(0, 1)));
      return;
    end
    send_item(ACT_RXBYTE, protect_id(id));
    while (fr_phase == PH_RXDATA || fr_phase == PH_TXDATA) begin
      if ($urandom_range(0, 49) == 0)
        return;
      if ($urandom_range(0, 19) == 0)
        send_item(2'($urandom), 8'($urandom));
      else
        send_item((fr_phase == PH_RXDATA) ? ACT_RXBYTE : ACT_TXBYTE, 8'($urandom));
    end
    if (fr_phase == PH_RXSUM)
      send_item(ACT_RXBYTE, ($urandom_range(0, 3) == 0) ? 8'($urandom) : ~fr_sum);
  endtask

  // Rounds of random frames, each under a new table; some rounds use the
  // extremes of every register.
  task automatic test_random_traffic();
    int          round;
    int          k;
    int          target;
    logic [23:0] ids;
    logic [23:0] roles;
    logic [23:0] sizes;
    for (round = 0; round < RANDOM_ROUNDS; round++) begin
      ids   = 24'($urandom);
      roles = 24'($urandom);
      sizes = 24'($urandom);
      for (k = 0; k < 4; k++) begin
        case ($urandom_range(0, 5))
          0, 1:    roles[2*k +: 2] = ROLE_LISTEN;
          2, 3:    roles[2*k +: 2] = ROLE_OWN;
          4:       roles[2*k +: 2] = ROLE_UNUSED;
          default: roles[2*k +: 2] = ROLE_SPARE;
        endcase
      end
      case (round)
        1: ids = '0;
        2: begin
          ids = '1;
          sizes[15:0] = '1;
        end
        3: roles[7:0] = {4{ROLE_OWN}};
        4: begin
          roles[7:0] = {4{ROLE_LISTEN}};
          sizes[15:0] = '0;
        end
        5: roles[7:0] = {4{ROLE_SPARE}};
        6: roles[7:0] = {4{ROLE_UNUSED}};
        7: sizes[15:0] = 16'h8888;
        default: ;
      endcase
      program_table(ids, roles, sizes, {23'($urandom), 1'(round)});
      target = handled_items + ROUND_ITEMS;
      while (handled_items < target)
        random_frame();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_header_checks();
    test_listener_response();
    test_owner_response();
    test_short_frames();
    test_random_traffic();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_events.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
